@@ rtl/core/mia_pkg.sv @@
// mia_pkg: shared constants, types and the permutation table for the matrix inverse core
// no dependencies; imported by mia_divider and matrix_inverse_adjugate_core
`timescale 1ns / 1ps
`default_nettype none

package mia_pkg;

   localparam int MAX_DIM    = 4;
   localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;
   localparam int ELEM_W     = 32;
   // exact determinant of a 4x4 of 32-bit elements stays below 2^129 in magnitude
   localparam int ACC_W      = 136;
   localparam int PROD_WORDS = 4;
   localparam int NUM_W      = ACC_W + 32;
   localparam int PERM_COUNT = 24;

   typedef logic [ACC_W-1:0] mia_wide_type;

   typedef struct packed {
      logic        done;
      logic        overflow;
      logic [31:0] quotient;
   } mia_div_status_type;

   // permutations of 0..3 in lexicographic order: bit 8 odd parity, bits 2i+1:2i give p(i)
   typedef logic [8:0] mia_perm_type;

   function automatic mia_perm_type perm_entry(input logic [4:0] idx);
      mia_perm_type e;
      case (idx)
         5'd0:  e = {1'b0, 2'd3, 2'd2, 2'd1, 2'd0};
         5'd1:  e = {1'b1, 2'd2, 2'd3, 2'd1, 2'd0};
         5'd2:  e = {1'b1, 2'd3, 2'd1, 2'd2, 2'd0};
         5'd3:  e = {1'b0, 2'd1, 2'd3, 2'd2, 2'd0};
         5'd4:  e = {1'b0, 2'd2, 2'd1, 2'd3, 2'd0};
         5'd5:  e = {1'b1, 2'd1, 2'd2, 2'd3, 2'd0};
         5'd6:  e = {1'b1, 2'd3, 2'd2, 2'd0, 2'd1};
         5'd7:  e = {1'b0, 2'd2, 2'd3, 2'd0, 2'd1};
         5'd8:  e = {1'b0, 2'd3, 2'd0, 2'd2, 2'd1};
         5'd9:  e = {1'b1, 2'd0, 2'd3, 2'd2, 2'd1};
         5'd10: e = {1'b1, 2'd2, 2'd0, 2'd3, 2'd1};
         5'd11: e = {1'b0, 2'd0, 2'd2, 2'd3, 2'd1};
         5'd12: e = {1'b0, 2'd3, 2'd1, 2'd0, 2'd2};
         5'd13: e = {1'b1, 2'd1, 2'd3, 2'd0, 2'd2};
         5'd14: e = {1'b1, 2'd3, 2'd0, 2'd1, 2'd2};
         5'd15: e = {1'b0, 2'd0, 2'd3, 2'd1, 2'd2};
         5'd16: e = {1'b0, 2'd1, 2'd0, 2'd3, 2'd2};
         5'd17: e = {1'b1, 2'd0, 2'd1, 2'd3, 2'd2};
         5'd18: e = {1'b1, 2'd2, 2'd1, 2'd0, 2'd3};
         5'd19: e = {1'b0, 2'd1, 2'd2, 2'd0, 2'd3};
         5'd20: e = {1'b0, 2'd2, 2'd0, 2'd1, 2'd3};
         5'd21: e = {1'b1, 2'd0, 2'd2, 2'd1, 2'd3};
         5'd22: e = {1'b1, 2'd1, 2'd0, 2'd2, 2'd3};
         5'd23: e = {1'b0, 2'd0, 2'd1, 2'd2, 2'd3};
         default: e = '0;
      endcase
      return e;
   endfunction

endpackage

`default_nettype wire

@@ rtl/core/matrix_inverse_adjugate_core.sv @@
// matrix_inverse_adjugate_core: top level, matrix store, determinant and cofactor engine
// depends on mia_pkg and mia_divider
`timescale 1ns / 1ps
`default_nettype none

// Loads an n by n matrix (n from csr_wdata, 1..4, default 4) one signed Q16.16
// element per transaction in row-major order, one per cycle. After the last
// element the core computes the exact determinant and then each inverse
// element as transposed cofactor over determinant, rounded toward zero and
// saturated to Q16.16, delivered in row-major order with tlast on the final
// one. A zero determinant gives singular in tuser and zero values. Each
// determinant is a sum over permutations walked through the matrix memory,
// one element read per product step and one 32x32 multiply per word of the
// running product; each quotient comes from a bit-serial division. A singular
// matrix only emits its zero results, one per cycle while rsp_tready does
// not stall them. No input is taken until the last result is registered.
// Writing the dimension during a load restarts the load.
module matrix_inverse_adjugate_core
   import mia_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_wen,
   input  wire logic [2:0]  csr_wdata,   // dimension
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,   // element_value
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [39:0]      rsp_tdata,   // inverse_value[31:0], out_row, out_col, zero pad
   output logic             rsp_tuser,   // singular
   output logic             rsp_tlast    // last_of_run
);

   typedef enum logic [3:0] {
      ST_LOAD, ST_PERM, ST_ELEM, ST_MUL, ST_ACC,
      ST_DETDONE, ST_COFDONE, ST_DIVSTART, ST_DIVWAIT, ST_OUT
   } state_type;

   logic [ELEM_W-1:0] store [STORE_DEPTH];
   logic [ELEM_W-1:0] rd_data_ff;

   state_type    state_ff;
   logic [2:0]   dim_ff;
   logic [4:0]   load_count_ff;
   logic         mode_cof_ff;
   logic [2:0]   k_ff;
   logic [1:0]   er_ff, ec_ff;
   logic [4:0]   pidx_ff;
   logic [2:0]   ei_ff;
   logic [1:0]   word_ff;
   logic [PROD_WORDS-1:0][31:0] prod_ff;
   logic [31:0]  carry_ff;
   logic         tsign_ff;
   mia_wide_type acc_ff;
   mia_wide_type dmag_ff;
   logic         dsign_ff;
   logic         sing_ff;
   mia_wide_type cmag_ff;
   logic         qneg_ff;
   logic [1:0]   row_ff, col_ff;
   logic [31:0]  val_ff;
   logic         div_start_ff;

   logic         rsp_valid_ff;
   logic [31:0]  rsp_val_ff;
   logic [1:0]   rsp_row_ff, rsp_col_ff;
   logic         rsp_sing_ff, rsp_last_ff;

   logic [2:0]   n_act;
   logic [4:0]   nn;
   mia_perm_type perm;
   logic         perm_ok;
   logic [1:0]   pcol;
   logic [2:0]   row_sel, col_sel;
   logic [4:0]   addr_full;
   logic [31:0]  m_mag;
   logic [63:0]  mul_p;
   mia_wide_type acc_sum;
   mia_wide_type cof_mag;
   logic [31:0]  sat_val;
   logic         out_free;
   logic         last_pos;
   logic [1:0]   next_row, next_col;
   logic         req_acc;
   mia_div_status_type div_status;

   mia_divider u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start_ff),
      .num_mag (cmag_ff),
      .den_mag (dmag_ff),
      .status  (div_status)
   );

   always_comb begin
      n_act = dim_ff;
      if (dim_ff == 3'd0) n_act = 3'd1;
      if (dim_ff > 3'(MAX_DIM)) n_act = 3'(MAX_DIM);
      nn = 5'(n_act) * 5'(n_act);

      perm = perm_entry(pidx_ff);
      perm_ok = 1'b1;
      for (int i = 0; i < MAX_DIM; i++) begin
         if ((3'(i) >= k_ff) && (perm[2*i +: 2] != 2'(i))) perm_ok = 1'b0;
      end
      pcol = perm[2*ei_ff[1:0] +: 2];
      // skip the removed row and column of a cofactor
      row_sel = (mode_cof_ff && (ei_ff >= {1'b0, er_ff})) ? ei_ff + 3'd1 : ei_ff;
      col_sel = (mode_cof_ff && (pcol >= ec_ff)) ? {1'b0, pcol} + 3'd1 : {1'b0, pcol};
      addr_full = 5'(row_sel[1:0]) * 5'(n_act) + 5'(col_sel[1:0]);

      m_mag = rd_data_ff[31] ? (32'd0 - rd_data_ff) : rd_data_ff;
      mul_p = 64'(prod_ff[0]) * 64'(m_mag) + 64'(carry_ff);

      acc_sum = tsign_ff ? (acc_ff - ACC_W'(prod_ff)) : (acc_ff + ACC_W'(prod_ff));
      // the cofactor sign only flips the quotient sign, the magnitude is that of the minor
      cof_mag = acc_ff[ACC_W-1] ? (ACC_W'(0) - acc_ff) : acc_ff;

      if (div_status.overflow || (div_status.quotient > (qneg_ff ? 32'h8000_0000
                                                                 : 32'h7fff_ffff)))
         sat_val = qneg_ff ? 32'h8000_0000 : 32'h7fff_ffff;
      else
         sat_val = qneg_ff ? (32'd0 - div_status.quotient) : div_status.quotient;

      out_free = !rsp_valid_ff || rsp_tready;
      last_pos = ({1'b0, row_ff} == n_act - 3'd1) && ({1'b0, col_ff} == n_act - 3'd1);
      if ({1'b0, col_ff} == n_act - 3'd1) begin
         next_col = 2'd0;
         next_row = row_ff + 2'd1;
      end else begin
         next_col = col_ff + 2'd1;
         next_row = row_ff;
      end
      req_acc = req_tvalid && (state_ff == ST_LOAD);
   end

   assign req_tready = (state_ff == ST_LOAD);

   always_ff @(posedge clock) begin
      if (req_acc) store[load_count_ff[3:0]] <= req_tdata;
      if (state_ff == ST_ELEM) rd_data_ff <= store[addr_full[3:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_LOAD;
         dim_ff        <= 3'(MAX_DIM);
         load_count_ff <= 5'd0;
         rsp_valid_ff  <= 1'b0;
         div_start_ff  <= 1'b0;
         pidx_ff       <= 5'd0;
      end else begin
         div_start_ff <= (state_ff == ST_DIVSTART);
         if ((state_ff == ST_OUT) && out_free) rsp_valid_ff <= 1'b1;
         else if (rsp_tready) rsp_valid_ff <= 1'b0;
         if (csr_wen) dim_ff <= csr_wdata;
         case (state_ff)
            ST_LOAD: begin
               if (csr_wen) begin
                  load_count_ff <= 5'd0;
               end else if (req_acc) begin
                  if (load_count_ff == nn - 5'd1) begin
                     load_count_ff <= 5'd0;
                     mode_cof_ff   <= 1'b0;
                     k_ff          <= n_act;
                     acc_ff        <= '0;
                     pidx_ff       <= 5'd0;
                     state_ff      <= ST_PERM;
                  end else begin
                     load_count_ff <= load_count_ff + 5'd1;
                  end
               end
            end
            ST_PERM: begin
               if (perm_ok) begin
                  prod_ff  <= {{(PROD_WORDS-1){32'd0}}, 32'd1};
                  tsign_ff <= perm[8];
                  ei_ff    <= 3'd0;
                  state_ff <= ST_ELEM;
               end else if (pidx_ff == 5'(PERM_COUNT - 1)) begin
                  state_ff <= mode_cof_ff ? ST_COFDONE : ST_DETDONE;
               end else begin
                  pidx_ff <= pidx_ff + 5'd1;
               end
            end
            ST_ELEM: begin
               if (ei_ff == k_ff) begin
                  state_ff <= ST_ACC;
               end else begin
                  word_ff  <= 2'd0;
                  carry_ff <= 32'd0;
                  state_ff <= ST_MUL;
               end
            end
            ST_MUL: begin
               // one word of the running product per cycle, rotated through
               prod_ff  <= {mul_p[31:0], prod_ff[PROD_WORDS-1:1]};
               carry_ff <= mul_p[63:32];
               if (word_ff == 2'd0) tsign_ff <= tsign_ff ^ rd_data_ff[31];
               if (word_ff == 2'(PROD_WORDS - 1)) begin
                  ei_ff    <= ei_ff + 3'd1;
                  state_ff <= ST_ELEM;
               end else begin
                  word_ff <= word_ff + 2'd1;
               end
            end
            ST_ACC: begin
               acc_ff <= acc_sum;
               if (pidx_ff == 5'(PERM_COUNT - 1)) begin
                  state_ff <= mode_cof_ff ? ST_COFDONE : ST_DETDONE;
               end else begin
                  pidx_ff  <= pidx_ff + 5'd1;
                  state_ff <= ST_PERM;
               end
            end
            ST_DETDONE: begin
               sing_ff  <= (acc_ff == '0);
               dsign_ff <= acc_ff[ACC_W-1];
               dmag_ff  <= acc_ff[ACC_W-1] ? (ACC_W'(0) - acc_ff) : acc_ff;
               row_ff   <= 2'd0;
               col_ff   <= 2'd0;
               val_ff   <= 32'd0;
               if (acc_ff == '0) begin
                  state_ff <= ST_OUT;
               end else begin
                  mode_cof_ff <= 1'b1;
                  k_ff        <= n_act - 3'd1;
                  er_ff       <= 2'd0;
                  ec_ff       <= 2'd0;
                  acc_ff      <= '0;
                  pidx_ff     <= 5'd0;
                  state_ff    <= ST_PERM;
               end
            end
            ST_COFDONE: begin
               qneg_ff  <= acc_ff[ACC_W-1] ^ row_ff[0] ^ col_ff[0] ^ dsign_ff;
               cmag_ff  <= cof_mag;
               state_ff <= ST_DIVSTART;
            end
            ST_DIVSTART: begin
               state_ff <= ST_DIVWAIT;
            end
            ST_DIVWAIT: begin
               if (div_status.done) begin
                  val_ff   <= sat_val;
                  state_ff <= ST_OUT;
               end
            end
            ST_OUT: begin
               if (out_free) begin
                  rsp_val_ff   <= sing_ff ? 32'd0 : val_ff;
                  rsp_row_ff   <= row_ff;
                  rsp_col_ff   <= col_ff;
                  rsp_sing_ff  <= sing_ff;
                  rsp_last_ff  <= last_pos;
                  row_ff       <= next_row;
                  col_ff       <= next_col;
                  if (last_pos) begin
                     state_ff <= ST_LOAD;
                  end else if (!sing_ff) begin
                     // cofactor of (r, c) drops row c and column r
                     k_ff     <= n_act - 3'd1;
                     er_ff    <= next_col;
                     ec_ff    <= next_row;
                     acc_ff   <= '0;
                     pidx_ff  <= 5'd0;
                     state_ff <= ST_PERM;
                  end
               end
            end
            default: state_ff <= ST_LOAD;
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'd0, rsp_col_ff, rsp_row_ff, rsp_val_ff};
   assign rsp_tuser  = rsp_sing_ff;
   assign rsp_tlast  = rsp_last_ff;

   a_sing_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[31:0] == 32'd0)
      else $error("singular result with nonzero value");

   a_load_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_LOAD |-> load_count_ff < nn)
      else $error("load count beyond matrix size");

   a_div_idle_load: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !div_status.done && !div_start_ff)
      else $error("divider active while loading");

   a_perm_bound: assert property (@(posedge clock) disable iff (reset)
      pidx_ff < 5'(PERM_COUNT))
      else $error("permutation index out of range");

endmodule

`default_nettype wire

@@ rtl/core/mia_divider.sv @@
// mia_divider: bit-serial restoring divider, trunc(num * 2^32 / den) on magnitudes
// depends on mia_pkg; reports the low 32 quotient bits and an overflow flag
`timescale 1ns / 1ps
`default_nettype none

module mia_divider
   import mia_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire mia_wide_type       num_mag,
   input  wire mia_wide_type       den_mag,
   output mia_div_status_type      status
);

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic [NUM_W-1:0] num_ff, num_in;
   logic [ACC_W:0]   rem_ff, rem_in;
   mia_wide_type     den_ff, den_in;
   logic [31:0]      q_ff, q_in;
   logic             big_ff, big_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;

   logic [ACC_W:0]   rem_sh;
   logic             ge;

   always_comb begin
      rem_sh = {rem_ff[ACC_W-1:0], num_ff[NUM_W-1]};
      ge     = rem_sh >= {1'b0, den_ff};
      num_in = num_ff;
      rem_in = rem_ff;
      den_in = den_ff;
      q_in   = q_ff;
      big_in = big_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         num_in  = {num_mag, 32'd0};
         den_in  = den_mag;
         rem_in  = '0;
         q_in    = '0;
         big_in  = 1'b0;
         cnt_in  = CNT_W'(NUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         num_in = {num_ff[NUM_W-2:0], 1'b0};
         rem_in = ge ? (rem_sh - {1'b0, den_ff}) : rem_sh;
         q_in   = {q_ff[30:0], ge};
         big_in = big_ff | q_ff[31];
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      q_ff   <= q_in;
      big_ff <= big_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign status.done     = done_ff;
   assign status.overflow = big_ff;
   assign status.quotient = q_ff;

endmodule

`default_nettype wire
